/* rtl/pkerl_pkg.sv */
// Package with the item types and fixed constants of the per-kind event rate limiter.
`timescale 1ns / 1ps

package pkerl_pkg;

  // Minimum gap between reported lines of one kind after reset: ten minutes in milliseconds.
  localparam logic [31:0] GAP_RESET = 32'd600000;

  typedef struct packed {
    logic [7:0]         kind_code;
    logic signed [31:0] event_value;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic               emit_line;
    logic [3:0]         kind_slot;
    logic signed [31:0] passed_value;
    logic [31:0]        suppressed_count;
    logic [31:0]        kind_total;
  } out_item_t;

  // Answer of the slot table for one item.
  typedef struct packed {
    logic        emit;
    logic [31:0] count;
    logic [31:0] total;
  } slot_rsp_t;

endpackage

/* rtl/pkerl_slot_table.sv */
// Per-slot state table with its read-modify-write update: combinational read, registered write.
`timescale 1ns / 1ps

module pkerl_slot_table
  import pkerl_pkg::*;
#(
  parameter int SLOTS  = 15,
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  logic [SLOT_W-1:0] req_slot,
  input  logic [31:0]       req_now,
  input  logic [31:0]       gap_ms,
  output slot_rsp_t         rsp
);

  logic        seen_r  [SLOTS];
  logic [31:0] last_r  [SLOTS];
  logic [31:0] held_r  [SLOTS];
  logic [31:0] total_r [SLOTS];

  logic        seen;
  logic [31:0] last_time;
  logic [31:0] held;
  logic [31:0] total;
  logic [31:0] elapsed;
  logic        hold;
  logic [31:0] held_inc;
  logic [31:0] held_nxt;
  logic [31:0] total_nxt;

  // An unseen slot has never taken an item, so its counters read as zero
  // whatever the storage holds.
  always_comb begin
    seen      = seen_r[req_slot];
    last_time = last_r[req_slot];
    held      = seen ? held_r[req_slot] : 32'd0;
    total     = seen ? total_r[req_slot] : 32'd0;
    elapsed   = req_now - last_time;
    hold      = seen && (elapsed < gap_ms);
    held_inc  = held + 32'd1;
    held_nxt  = hold ? held_inc : 32'd0;
    total_nxt = total + 32'd1;
    rsp.emit  = !hold;
    rsp.count = hold ? held_inc : held;
    rsp.total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        seen_r[i] <= 1'b0;
      end
    end else if (req_valid) begin
      seen_r[req_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      total_r[req_slot] <= total_nxt;
      held_r[req_slot]  <= held_nxt;
      if (!hold) begin
        last_r[req_slot] <= req_now;
      end
    end
  end

endmodule

/* rtl/per_kind_event_rate_limiter_core.sv */
// Top level of the per-kind event rate limiter: input register, slot table, result register.
`timescale 1ns / 1ps
// Timing: an accepted item is held in the input register, then its result shows on
//   out_data, marked by out_valid, for exactly one cycle from the result register.
// Throughput: one item per cycle; busy is never raised, and the slot table does its
//   read-modify-write at the input register so consecutive same-kind items chain correctly.
// Reset: synchronous, active low; clears all seen flags, pipeline valids, and sets gap_ms
//   to ten minutes. The receiver cannot stall, so results are never held.

module per_kind_event_rate_limiter_core
  import pkerl_pkg::*;
#(
  parameter int NAMED_KINDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // One slot per named kind plus one overflow slot shared by all other codes.
  localparam int SLOTS  = NAMED_KINDS + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [7:0]        NAMED_CODE = 8'(NAMED_KINDS);
  localparam logic [SLOT_W-1:0] OVF_SLOT   = SLOT_W'(NAMED_KINDS);

  logic [31:0]        gap_r;
  logic               in_valid_r;
  logic [SLOT_W-1:0]  in_slot_r;
  logic signed [31:0] in_val_r;
  logic [31:0]        in_now_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic [SLOT_W-1:0]  slot_nxt;
  slot_rsp_t          rsp;
  out_item_t          out_data_nxt;

  // The slot table never holds up an item, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp the raw code: anything at or above the named kind count goes to the overflow slot.
  assign slot_nxt = (in_data.kind_code < NAMED_CODE) ? SLOT_W'(in_data.kind_code) : OVF_SLOT;

  // Configuration register. The user must write it only while no item is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_we) begin
      gap_r <= cfg_wdata;
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_slot_r <= slot_nxt;
      in_val_r  <= in_data.event_value;
      in_now_r  <= in_data.now_ms;
    end
  end

  // The table updates its state at the same edge that captures the result, so the
  // next item in the input register already sees this item's effect.
  pkerl_slot_table #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_slot_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid_r),
    .req_slot  (in_slot_r),
    .req_now   (in_now_r),
    .gap_ms    (gap_r),
    .rsp       (rsp)
  );

  always_comb begin
    out_data_nxt.emit_line        = rsp.emit;
    out_data_nxt.kind_slot        = 4'(in_slot_r);
    out_data_nxt.passed_value     = in_val_r;
    out_data_nxt.suppressed_count = rsp.count;
    out_data_nxt.kind_total       = rsp.total;
  end

  // Result register: each result is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/pkerl_checker.sv */
// Port-level checker for the rate limiter core and the bind that attaches it.
`timescale 1ns / 1ps

module pkerl_checker
  import pkerl_pkg::*;
#(
  parameter int NAMED_KINDS = 14
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input in_item_t    in_data,
  input logic        out_valid,
  input out_item_t   out_data
);

  localparam logic [7:0] NAMED_CODE = 8'(NAMED_KINDS);
  localparam logic [3:0] OVF_SLOT4  = 4'(NAMED_KINDS);

  logic [3:0] exp_slot;

  assign exp_slot = (in_data.kind_code < NAMED_CODE) ? 4'(in_data.kind_code) : OVF_SLOT4;

  // Every accepted item yields a result after the input register and the result register.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // No result appears without a matching accepted item ahead of it in the pipeline.
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_value_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.passed_value == $past(in_data.event_value, 2)))
    else $error("passed value differs from the item value");

  a_slot_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind_slot == $past(exp_slot, 2)))
    else $error("kind slot not clamped correctly");

endmodule

bind per_kind_event_rate_limiter_core pkerl_checker #(
  .NAMED_KINDS (NAMED_KINDS)
) u_pkerl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
